// ===== sv/hslcc_pkg.sv =====
// Shared types and constants for the RGB565 to HSL color classifier.
package hslcc_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LUM_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LUM_HIGH = 3'd5;

    localparam logic [7:0] HUE_LOW_RST  = 8'd173;
    localparam logic [7:0] HUE_HIGH_RST = 8'd240;
    localparam logic [7:0] SAT_LOW_RST  = 8'd160;
    localparam logic [7:0] SAT_HIGH_RST = 8'd240;
    localparam logic [7:0] LUM_LOW_RST  = 8'd78;
    localparam logic [7:0] LUM_HIGH_RST = 8'd178;

    // Channel that holds the maximum, in priority order red, green, blue
    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;

    // Saturation result selection
    localparam logic [1:0] SAT_ZERO = 2'd0;
    localparam logic [1:0] SAT_FULL = 2'd1;
    localparam logic [1:0] SAT_DIV  = 2'd2;

    localparam logic [7:0] SCALE_MAX      = 8'd240;
    localparam logic [7:0] HUE_BASE_GREEN = 8'd80;
    localparam logic [7:0] HUE_BASE_BLUE  = 8'd160;

    // lum = floor(sum * 8 / 17); these sums bound lum == 0 and lum <= 120
    localparam logic [8:0] SUM_LUM_ZERO_MAX = 9'd2;
    localparam logic [8:0] SUM_LUM_LOW_MAX  = 9'd257;
    localparam logic [8:0] SUM_SAT_PEAK     = 9'd480;

    // floor(x / 17) = (x * 3856) >> 16 for x < 4096; x = 8 * sum folded in
    localparam logic [14:0] LUM_RECIP = 15'd30848;

    // Restoring divider: one quotient bit per stage
    localparam int DIV_STAGES = 8;
    localparam int QUO_W      = 8;

    typedef struct packed {
        logic [7:0] hue_low;
        logic [7:0] hue_high;
        logic [7:0] sat_low;
        logic [7:0] sat_high;
        logic [7:0] lum_low;
        logic [7:0] lum_high;
    } cfg_t;

    typedef struct packed {
        logic [15:0]      rem;
        logic [8:0]       den;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic       grey;
        logic [1:0] hue_chan;
        logic       hue_neg;
        logic [1:0] sat_mode;
        logic       sat_ovf;
        logic [7:0] lum;
        div_lane_t  hue;
        div_lane_t  sat;
    } pipe_t;

endpackage

// ===== sv/hslcc_front.sv =====
// Front end: byte swap, unpack, min/max, then divider operand setup.
module hslcc_front
    import hslcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [15:0] pixel_word,
    output logic        out_valid,
    output pipe_t       out_data
);

    typedef struct packed {
        logic [7:0] d;
        logic [8:0] sum;
        logic [1:0] chan;
        logic [8:0] diff;
    } front_a_t;

    logic [15:0] swapped;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  max_val;
    logic [7:0]  min_val;
    front_a_t    a_next;
    front_a_t    a_reg;
    logic        a_valid_reg;

    logic [7:0]  hue_abs;
    logic [15:0] hue_num;
    logic [15:0] sat_num;
    logic [9:0]  den_hi;
    logic [8:0]  sat_den;
    logic [23:0] lum_prod;
    pipe_t       b_next;
    pipe_t       b_reg;
    logic        b_valid_reg;

    // Swap bytes and left-align each channel to 8 bits
    always_comb
    begin
        swapped = {pixel_word[7:0], pixel_word[15:8]};
        red     = {swapped[15:11], 3'b000};
        green   = {swapped[10:5], 2'b00};
        blue    = {swapped[4:0], 3'b000};
    end

    // Find max, min and the hue channel
    always_comb
    begin
        max_val = red;
        if (green > max_val)
        begin
            max_val = green;
        end
        if (blue > max_val)
        begin
            max_val = blue;
        end
        min_val = red;
        if (green < min_val)
        begin
            min_val = green;
        end
        if (blue < min_val)
        begin
            min_val = blue;
        end

        a_next.d   = max_val - min_val;
        a_next.sum = {1'b0, max_val} + {1'b0, min_val};
        if (max_val == red)
        begin
            a_next.chan = CHAN_RED;
            a_next.diff = {1'b0, green} - {1'b0, blue};
        end
        else if (max_val == green)
        begin
            a_next.chan = CHAN_GREEN;
            a_next.diff = {1'b0, blue} - {1'b0, red};
        end
        else
        begin
            a_next.chan = CHAN_BLUE;
            a_next.diff = {1'b0, red} - {1'b0, green};
        end
    end

    // Stage A valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    // Stage A payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            a_reg <= a_next;
        end
    end

    // Build divider operands, saturation mode and luminance
    always_comb
    begin
        hue_abs  = a_reg.diff[8] ? 8'(~a_reg.diff + 9'd1) : a_reg.diff[7:0];
        hue_num  = {3'b000, hue_abs, 5'b00000} + {5'b00000, hue_abs, 3'b000};
        sat_num  = {a_reg.d, 8'h00} - {4'h0, a_reg.d, 4'h0};
        den_hi   = {1'b0, SUM_SAT_PEAK} - {1'b0, a_reg.sum};
        lum_prod = {15'd0, a_reg.sum} * {9'd0, LUM_RECIP};

        sat_den         = a_reg.sum;
        b_next.sat_mode = SAT_DIV;
        if (a_reg.d == 8'd0 || a_reg.sum <= SUM_LUM_ZERO_MAX)
        begin
            b_next.sat_mode = SAT_ZERO;
        end
        else if (a_reg.sum <= SUM_LUM_LOW_MAX)
        begin
            sat_den = a_reg.sum;
        end
        else if (a_reg.sum == SUM_SAT_PEAK)
        begin
            b_next.sat_mode = SAT_FULL;
        end
        else if (a_reg.sum > SUM_SAT_PEAK)
        begin
            // negative denominator: quotient clamps to zero
            b_next.sat_mode = SAT_ZERO;
        end
        else
        begin
            sat_den = den_hi[8:0];
        end

        b_next.grey     = (a_reg.d == 8'd0);
        b_next.hue_chan = a_reg.chan;
        b_next.hue_neg  = a_reg.diff[8];
        b_next.sat_ovf  = ({1'b0, sat_num} >= {sat_den, 8'h00});
        b_next.lum      = lum_prod[23:16];
        b_next.hue.rem  = hue_num;
        b_next.hue.den  = {1'b0, a_reg.d};
        b_next.hue.quo  = '0;
        b_next.sat.rem  = sat_num;
        b_next.sat.den  = sat_den;
        b_next.sat.quo  = '0;
    end

    // Stage B valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage B payload
    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule

// ===== sv/hslcc_div_stage.sv =====
// One restoring-division step for the hue and saturation lanes.
module hslcc_div_stage
    import hslcc_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  pipe_t in_data,
    output logic  out_valid,
    output pipe_t out_data
);

    pipe_t stage_next;
    pipe_t stage_reg;
    logic  valid_reg;

    // Subtract the shifted divisor when it fits and set this quotient bit
    function automatic div_lane_t div_step(input div_lane_t lane);
        div_lane_t   res;
        logic [16:0] trial;
        logic [16:0] rem_ext;
        res     = lane;
        trial   = {8'd0, lane.den} << BIT;
        rem_ext = {1'b0, lane.rem};
        if (rem_ext >= trial)
        begin
            res.rem      = lane.rem - trial[15:0];
            res.quo[BIT] = 1'b1;
        end
        return res;
    endfunction

    always_comb
    begin
        stage_next     = in_data;
        stage_next.hue = div_step(in_data.hue);
        stage_next.sat = div_step(in_data.sat);
    end

    // Advance valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = stage_reg;

endmodule

// ===== sv/hslcc_back.sv =====
// Back end: compose hue, select saturation, window test, output register.
module hslcc_back
    import hslcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  pipe_t      in_data,
    input  cfg_t       cfg,
    output logic       done,
    output logic [7:0] hue_out,
    output logic [7:0] sat_out,
    output logic [7:0] lum_out,
    output logic       in_window
);

    logic [7:0] hue_base;
    logic [8:0] hue_sum;
    logic [7:0] hue_val;
    logic [7:0] sat_val;
    logic       win_next;
    logic       done_reg;
    logic [7:0] hue_reg;
    logic [7:0] sat_reg;
    logic [7:0] lum_reg;
    logic       win_reg;

    // Offset the hue quotient from the sector base
    always_comb
    begin
        case (in_data.hue_chan)
            CHAN_RED:   hue_base = in_data.hue_neg ? SCALE_MAX : 8'd0;
            CHAN_GREEN: hue_base = HUE_BASE_GREEN;
            default:    hue_base = HUE_BASE_BLUE;
        endcase
        if (in_data.hue_neg)
        begin
            hue_sum = {1'b0, hue_base} - {1'b0, in_data.hue.quo};
        end
        else
        begin
            hue_sum = {1'b0, hue_base} + {1'b0, in_data.hue.quo};
        end
        hue_val = in_data.grey ? 8'd0 : hue_sum[7:0];
    end

    // Select saturation and clamp overflow
    always_comb
    begin
        case (in_data.sat_mode)
            SAT_FULL: sat_val = SCALE_MAX;
            SAT_DIV:  sat_val = (in_data.sat_ovf || in_data.sat.quo > SCALE_MAX) ?
                                SCALE_MAX : in_data.sat.quo;
            default:  sat_val = 8'd0;
        endcase
    end

    // Test all three against the inclusive bounds
    always_comb
    begin
        win_next = (hue_val >= cfg.hue_low) && (hue_val <= cfg.hue_high) &&
                   (sat_val >= cfg.sat_low) && (sat_val <= cfg.sat_high) &&
                   (in_data.lum >= cfg.lum_low) && (in_data.lum <= cfg.lum_high);
    end

    // Strobe one cycle per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            hue_reg <= hue_val;
            sat_reg <= sat_val;
            lum_reg <= in_data.lum;
            win_reg <= win_next;
        end
    end

    assign done      = done_reg;
    assign hue_out   = hue_reg;
    assign sat_out   = sat_reg;
    assign lum_out   = lum_reg;
    assign in_window = win_reg;

endmodule

// ===== sv/rgb565_hsl_color_classifier_unit.sv =====
// Each accepted start yields one done strobe once its result reaches the output register.
// Throughput: one item per cycle; two front stages, an eight-stage restoring
// divider (one quotient bit per stage) and an output register set the depth.
// busy stays low: the pipeline never stalls; the receiver must take every result, not enforced by the block.
// Reset clears all valid bits and loads the window registers with their defaults.
module rgb565_hsl_color_classifier_unit
    import hslcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [15:0]           pixel_word,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [7:0]            hue_out,
    output logic [7:0]            sat_out,
    output logic [7:0]            lum_out,
    output logic                  in_window
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  accept;
    logic  div_valid [0:DIV_STAGES];
    pipe_t div_data  [0:DIV_STAGES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode configuration writes; unknown indexes drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_HUE_LOW:  cfg_next.hue_low  = cfg_data;
                CFG_HUE_HIGH: cfg_next.hue_high = cfg_data;
                CFG_SAT_LOW:  cfg_next.sat_low  = cfg_data;
                CFG_SAT_HIGH: cfg_next.sat_high = cfg_data;
                CFG_LUM_LOW:  cfg_next.lum_low  = cfg_data;
                CFG_LUM_HIGH: cfg_next.lum_high = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_low  <= HUE_LOW_RST;
            cfg_reg.hue_high <= HUE_HIGH_RST;
            cfg_reg.sat_low  <= SAT_LOW_RST;
            cfg_reg.sat_high <= SAT_HIGH_RST;
            cfg_reg.lum_low  <= LUM_LOW_RST;
            cfg_reg.lum_high <= LUM_HIGH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hslcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .pixel_word (pixel_word),
        .out_valid  (div_valid[0]),
        .out_data   (div_data[0])
    );

    // Divider chain, quotient MSB first
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        hslcc_div_stage #(
            .BIT (DIV_STAGES - 1 - s)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[s]),
            .in_data   (div_data[s]),
            .out_valid (div_valid[s+1]),
            .out_data  (div_data[s+1])
        );
    end

    hslcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_data   (div_data[DIV_STAGES]),
        .cfg       (cfg_reg),
        .done      (done),
        .hue_out   (hue_out),
        .sat_out   (sat_out),
        .lum_out   (lum_out),
        .in_window (in_window)
    );

endmodule

// ===== sv/hslcc_checker.sv =====
// Port-level checker for the color classifier, with its bind.
module hslcc_checker
    import hslcc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  done,
    input logic [7:0]            hue_out,
    input logic [7:0]            sat_out,
    input logic [7:0]            lum_out,
    input logic                  in_window
);

    localparam logic [3:0] LATENCY = 4'd11;

    logic [3:0] warm_reg;
    cfg_t       cfg_reg;

    // Count edges since reset, saturating at the pipeline depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= 4'd0;
        end
        else if (warm_reg != LATENCY)
        begin
            warm_reg <= warm_reg + 4'd1;
        end
    end

    // Mirror the window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_low  <= HUE_LOW_RST;
            cfg_reg.hue_high <= HUE_HIGH_RST;
            cfg_reg.sat_low  <= SAT_LOW_RST;
            cfg_reg.sat_high <= SAT_HIGH_RST;
            cfg_reg.lum_low  <= LUM_LOW_RST;
            cfg_reg.lum_high <= LUM_HIGH_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_HUE_LOW)  cfg_reg.hue_low  <= cfg_data;
            if (cfg_index == CFG_HUE_HIGH) cfg_reg.hue_high <= cfg_data;
            if (cfg_index == CFG_SAT_LOW)  cfg_reg.sat_low  <= cfg_data;
            if (cfg_index == CFG_SAT_HIGH) cfg_reg.sat_high <= cfg_data;
            if (cfg_index == CFG_LUM_LOW)  cfg_reg.lum_low  <= cfg_data;
            if (cfg_index == CFG_LUM_HIGH) cfg_reg.lum_high <= cfg_data;
        end
    end

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised: pipeline must take an item every cycle");

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (warm_reg == LATENCY) |-> (done == $past(start && !busy, 11)))
        else $error("done does not follow an accepted item by 11 cycles");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue_out <= SCALE_MAX && sat_out <= SCALE_MAX && lum_out <= SCALE_MAX))
        else $error("result field above 240");

    a_window_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_window) |->
            (hue_out >= cfg_reg.hue_low && hue_out <= cfg_reg.hue_high &&
             sat_out >= cfg_reg.sat_low && sat_out <= cfg_reg.sat_high &&
             lum_out >= cfg_reg.lum_low && lum_out <= cfg_reg.lum_high))
        else $error("in_window set for a result outside the bounds");

endmodule

bind rgb565_hsl_color_classifier_unit hslcc_checker u_hslcc_checker (.*);
